// ----- src/tipdr_pkg.sv -----
// ----------------------------------------------------------------------------
// tipdr_pkg: shared definitions for the typed index pool
// Widths, codes, item structures and the effective-size helper that the
// register file and the pool controller both use.
// ----------------------------------------------------------------------------
package tipdr_pkg;

   localparam int POOL_DEPTH    = 64;
   localparam int TYPE_COUNT    = 5;
   localparam int NUM_SIZE_REGS = 5;

   localparam int IDX_W    = $clog2(POOL_DEPTH);
   localparam int CNT_W    = $clog2(POOL_DEPTH + 1);
   localparam int TYPE_W   = $clog2(TYPE_COUNT);
   localparam int SIZE_W   = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int RCNT_W   = 9;
   localparam int MEM_DEPTH = TYPE_COUNT * POOL_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(4 * NUM_SIZE_REGS);
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
   localparam logic [OP_W-1:0] OP_DISCARD     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET_STALE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   kind;
      logic [TYPE_W-1:0] pool_sel;
      logic [IDX_W-1:0]  index;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_index;
      logic [RCNT_W-1:0]   reset_count;
      logic [CNT_W-1:0]    peak_in_use;
   } rsp_item_type;

   // A size register write that also reinitialises its pool.
   typedef struct packed {
      logic              valid;
      logic [TYPE_W-1:0] pool;
      logic [SIZE_W-1:0] size;
   } cfg_write_type;

   typedef logic [TYPE_COUNT-1:0][SIZE_W-1:0] size_array_type;

   // Pool size as used by the logic: the register value limited to the depth.
   function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [CNT_W-1:0] r;
      if (s > SIZE_W'(POOL_DEPTH)) begin
         r = CNT_W'(POOL_DEPTH);
      end else begin
         r = CNT_W'(s);
      end
      return r;
   endfunction

endpackage

// ----- src/tipdr_ram.sv -----
// ----------------------------------------------------------------------------
// tipdr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module tipdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tipdr_csr.sv -----
// ----------------------------------------------------------------------------
// tipdr_csr: pool size register file
// Holds the size registers behind an APB-style port and reports each write
// so that the controller can reinitialise the pool concerned.
// ----------------------------------------------------------------------------
module tipdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tipdr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tipdr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tipdr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output tipdr_pkg::size_array_type           size_regs,
   output tipdr_pkg::cfg_write_type            cfg_wr
);
   import tipdr_pkg::*;

   size_array_type       size_ff;
   size_array_type       size_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 idx_ok;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign idx_ok  = (reg_idx < CSR_IDX_W'(NUM_SIZE_REGS))
                    && (reg_idx < CSR_IDX_W'(TYPE_COUNT));

   always_comb begin
      cfg_wr.valid = psel && penable && pwrite && idx_ok;
      cfg_wr.pool  = TYPE_W'(reg_idx);
      cfg_wr.size  = pwdata[SIZE_W-1:0];
      size_in      = size_ff;
      if (cfg_wr.valid) begin
         size_in[cfg_wr.pool] = cfg_wr.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= {TYPE_COUNT{SIZE_RESET}};
      end else begin
         size_ff <= size_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (idx_ok) begin
         prdata = CSR_DATA_W'(size_ff[TYPE_W'(reg_idx)]);
      end
   end

   assign pready    = 1'b1;
   assign size_regs = size_ff;

endmodule

// ----- src/typed_index_pool_with_deferred_reclaim.sv -----
// ----------------------------------------------------------------------------
// typed_index_pool_with_deferred_reclaim: per-kind index allocator
// Five pools of small indices, one per query kind. Allocate pops from the back
// of a kind's free ring, discard parks an index on the kind's stale list, and
// reset-stale moves each parked index to the front of its ring if it has room.
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_ready  req_item_type (kind, pool_sel, index)
//   rsp_      out        rsp_valid/rsp_ready  rsp_item_type (status, granted_index,
//                                             reset_count, peak_in_use)
//   csr_      in/out     APB-style, pready=1  five 7-bit pool size registers
//
// Allocate, discard and the unused opcode issue the free ring read in the
// accept cycle, then commit and answer from ST_EXEC once the output
// register is free. Reset-stale leaves ST_EXEC for a walk that reads the
// stale memory one entry per cycle and closes each kind's list once its
// entries are read, then answers from ST_WDONE.
// Reset needs no clearing pass; a per-pool count of front pushes tells which
// ring slots still hold their initial value.
// A waiting result in the output register stalls the next commit, not the
// acceptance of the next item.
// ----------------------------------------------------------------------------
module typed_index_pool_with_deferred_reclaim (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tipdr_pkg::req_item_type          req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tipdr_pkg::rsp_item_type          rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tipdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tipdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tipdr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import tipdr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_WDONE
   } state_type;

   typedef logic [TYPE_COUNT-1:0][IDX_W-1:0] head_array_type;
   typedef logic [TYPE_COUNT-1:0][CNT_W-1:0] cnt_array_type;

   // Configuration registers.
   size_array_type size_regs;
   cfg_write_type  cfg_wr;

   // Sequencer and item registers.
   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [TYPE_W-1:0] qt_ff, qt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Per-pool bookkeeping. pushed counts the pushes onto the front of the
   // ring since the pool was last initialised, saturating at the depth.
   head_array_type free_head_ff, free_head_in;
   cnt_array_type  free_count_ff, free_count_in;
   cnt_array_type  stale_count_ff, stale_count_in;
   cnt_array_type  peak_ff, peak_in;
   cnt_array_type  pushed_ff, pushed_in;

   // Stale walk: read stage and one pending write stage behind it.
   logic [TYPE_W-1:0] walk_kind_ff, walk_kind_in;
   logic [CNT_W-1:0]  walk_pos_ff, walk_pos_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [TYPE_W-1:0] pend_kind_ff, pend_kind_in;
   logic [RCNT_W-1:0] moved_ff, moved_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic              free_wr_en, free_rd_en;
   logic [MEM_AW-1:0] free_wr_addr, free_rd_addr;
   logic [IDX_W-1:0]  free_rd_data;
   logic              stale_wr_en, stale_rd_en;
   logic [MEM_AW-1:0] stale_wr_addr, stale_rd_addr;
   logic [IDX_W-1:0]  stale_rd_data;

   // Accept-cycle read address.
   logic              req_ok;
   logic [TYPE_W-1:0] req_qs;
   logic [IDX_W-1:0]  req_pos;

   // Commit-cycle decode of the held item.
   logic              ex_ok;
   logic [TYPE_W-1:0] ex_qs;
   logic [CNT_W-1:0]  ex_cnt, ex_cnt_dec, ex_size, ex_used, ex_peak_new, ex_orig_sum;
   logic [IDX_W-1:0]  ex_pos, ex_granted;
   logic              disc_ok;

   // Pending push stage.
   logic             pd_room;
   logic [IDX_W-1:0] pd_head;

   logic walk_issue;
   logic out_free;

   tipdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .size_regs (size_regs),
      .cfg_wr    (cfg_wr)
   );

   tipdr_ram #(.WIDTH(IDX_W), .DEPTH(MEM_DEPTH)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (stale_rd_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   tipdr_ram #(.WIDTH(IDX_W), .DEPTH(MEM_DEPTH)) u_stale_ram (
      .clock   (clock),
      .wr_en   (stale_wr_en),
      .wr_addr (stale_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (stale_rd_en),
      .rd_addr (stale_rd_addr),
      .rd_data (stale_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // The back of the ring sits at head + count - 1; the ring wraps at the
   // depth, which is a power of two, so truncation does the modulo.
   assign req_ok  = req_data.pool_sel < TYPE_W'(TYPE_COUNT);
   assign req_qs  = req_ok ? req_data.pool_sel : '0;
   assign req_pos = free_head_ff[req_qs] + free_count_ff[req_qs][IDX_W-1:0] - IDX_W'(1);

   assign ex_ok      = qt_ff < TYPE_W'(TYPE_COUNT);
   assign ex_qs      = ex_ok ? qt_ff : '0;
   assign ex_cnt     = free_count_ff[ex_qs];
   assign ex_cnt_dec = ex_cnt - CNT_W'(1);
   assign ex_size    = eff_size(size_regs[ex_qs]);
   assign ex_pos     = free_head_ff[ex_qs] + ex_cnt[IDX_W-1:0] - IDX_W'(1);
   assign ex_used    = (ex_size > ex_cnt_dec) ? (ex_size - ex_cnt_dec) : '0;
   assign ex_peak_new = (ex_used > peak_ff[ex_qs]) ? ex_used : peak_ff[ex_qs];

   // Slots at or above depth - pushed have been written by the walk; the
   // others still hold their initial value, which is the slot number inside
   // the pool size and zero beyond it.
   assign ex_orig_sum = CNT_W'(ex_pos) + pushed_ff[ex_qs];
   always_comb begin
      if (ex_orig_sum >= CNT_W'(POOL_DEPTH)) begin
         ex_granted = free_rd_data;
      end else if (CNT_W'(ex_pos) < ex_size) begin
         ex_granted = ex_pos;
      end else begin
         ex_granted = '0;
      end
   end

   assign disc_ok = ex_ok && (CNT_W'(idx_ff) < ex_size)
                    && (stale_count_ff[ex_qs] < CNT_W'(POOL_DEPTH));

   assign pd_room = free_count_ff[pend_kind_ff] < CNT_W'(POOL_DEPTH);
   assign pd_head = free_head_ff[pend_kind_ff] - IDX_W'(1);

   assign walk_issue = (state_ff == ST_WALK)
                       && (walk_pos_ff < stale_count_ff[walk_kind_ff]);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      qt_in          = qt_ff;
      idx_in         = idx_ff;
      free_head_in   = free_head_ff;
      free_count_in  = free_count_ff;
      stale_count_in = stale_count_ff;
      peak_in        = peak_ff;
      pushed_in      = pushed_ff;
      walk_kind_in   = walk_kind_ff;
      walk_pos_in    = walk_pos_ff;
      pend_valid_in  = 1'b0;
      pend_kind_in   = pend_kind_ff;
      moved_in       = moved_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      free_rd_en    = 1'b0;
      free_rd_addr  = {req_qs, req_pos};
      free_wr_en    = 1'b0;
      free_wr_addr  = {pend_kind_ff, pd_head};
      stale_wr_en   = 1'b0;
      stale_wr_addr = {ex_qs, stale_count_ff[ex_qs][IDX_W-1:0]};
      stale_rd_en   = walk_issue;
      stale_rd_addr = {walk_kind_ff, walk_pos_ff[IDX_W-1:0]};

      // A size write rebuilds its pool; the user must issue it while idle (not enforced).
      if (cfg_wr.valid) begin
         free_head_in[cfg_wr.pool]   = '0;
         free_count_in[cfg_wr.pool]  = eff_size(cfg_wr.size);
         stale_count_in[cfg_wr.pool] = '0;
         peak_in[cfg_wr.pool]        = '0;
         pushed_in[cfg_wr.pool]      = '0;
      end

      // Push of a stale index read in the previous cycle onto the front of
      // its ring. A full ring drops it uncounted.
      if (pend_valid_ff && pd_room) begin
         free_wr_en                  = 1'b1;
         free_head_in[pend_kind_ff]  = pd_head;
         free_count_in[pend_kind_ff] = free_count_ff[pend_kind_ff] + CNT_W'(1);
         moved_in                    = moved_ff + RCNT_W'(1);
         if (pushed_ff[pend_kind_ff] < CNT_W'(POOL_DEPTH)) begin
            pushed_in[pend_kind_ff] = pushed_ff[pend_kind_ff] + CNT_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               free_rd_en = 1'b1;
               op_in      = req_data.kind;
               qt_in      = req_data.pool_sel;
               idx_in     = req_data.index;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_RESET_STALE) begin
               walk_kind_in = '0;
               walk_pos_in  = '0;
               moved_in     = '0;
               state_in     = ST_WALK;
            end else if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = STATUS_OK;
               rsp_data_in.granted_index = '0;
               rsp_data_in.reset_count   = '0;
               rsp_data_in.peak_in_use   = ex_ok ? peak_ff[ex_qs] : '0;
               if (op_ff == OP_ALLOC) begin
                  if (!ex_ok || ex_cnt == '0) begin
                     rsp_data_in.status = STATUS_EMPTY;
                  end else begin
                     free_count_in[ex_qs]      = ex_cnt_dec;
                     peak_in[ex_qs]            = ex_peak_new;
                     rsp_data_in.granted_index = ex_granted;
                     rsp_data_in.peak_in_use   = ex_peak_new;
                  end
               end else if (op_ff == OP_DISCARD) begin
                  if (disc_ok) begin
                     stale_wr_en           = 1'b1;
                     stale_count_in[ex_qs] = stale_count_ff[ex_qs] + CNT_W'(1);
                  end else begin
                     rsp_data_in.status = STATUS_RANGE;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_issue) begin
               pend_valid_in = 1'b1;
               pend_kind_in  = walk_kind_ff;
               walk_pos_in   = walk_pos_ff + CNT_W'(1);
            end else begin
               stale_count_in[walk_kind_ff] = '0;
               walk_pos_in                  = '0;
               if (walk_kind_ff == TYPE_W'(TYPE_COUNT - 1)) begin
                  state_in = ST_WDONE;
               end else begin
                  walk_kind_in = walk_kind_ff + TYPE_W'(1);
               end
            end
         end
         ST_WDONE: begin
            // The last pending push landed no later than the cycle that closed the
            // final kind's list, so the count is complete here.
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = STATUS_OK;
               rsp_data_in.granted_index = '0;
               rsp_data_in.reset_count   = moved_in;
               rsp_data_in.peak_in_use   = ex_ok ? peak_ff[ex_qs] : '0;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         op_ff          <= OP_ALLOC;
         qt_ff          <= '0;
         idx_ff         <= '0;
         free_head_ff   <= '0;
         free_count_ff  <= {TYPE_COUNT{eff_size(SIZE_RESET)}};
         stale_count_ff <= '0;
         peak_ff        <= '0;
         pushed_ff      <= '0;
         walk_kind_ff   <= '0;
         walk_pos_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         pend_kind_ff   <= '0;
         moved_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         qt_ff          <= qt_in;
         idx_ff         <= idx_in;
         free_head_ff   <= free_head_in;
         free_count_ff  <= free_count_in;
         stale_count_ff <= stale_count_in;
         peak_ff        <= peak_in;
         pushed_ff      <= pushed_in;
         walk_kind_ff   <= walk_kind_in;
         walk_pos_ff    <= walk_pos_in;
         pend_valid_ff  <= pend_valid_in;
         pend_kind_ff   <= pend_kind_in;
         moved_ff       <= moved_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A pending push always belongs to the kind the walk was reading in the
   // previous cycle.
   a_pend_kind : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ($past(state_ff) == ST_WALK) && (pend_kind_ff == $past(walk_kind_ff)))
      else $error("pending push does not match the walk");

   // Once the walk has finished, every stale list has been emptied.
   a_stale_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WDONE) |-> (stale_count_ff == '0))
      else $error("stale list left over after the walk");

   // A new result only ever comes from the commit cycle or the walk end.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC) || ($past(state_ff) == ST_WDONE))
      else $error("result raised outside a commit cycle");

   // The walk position never runs past the depth of a stale list.
   a_walk_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_pos_ff <= CNT_W'(POOL_DEPTH)))
      else $error("walk position beyond the list depth");

endmodule

// ----- tb/sv/index_pool_checker.sv -----
// ----------------------------------------------------------------------------
// index_pool_checker: predicts and checks the typed index pool
// Watches the request, result and register channels, keeps its own copy of
// every pool and compares each result item, field by field, with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module index_pool_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  tipdr_pkg::req_item_type          req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  tipdr_pkg::rsp_item_type          rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic                             csr_pready,
   input  logic [tipdr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tipdr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                               fail_count,
   output int                               pending,
   output int                               replies_checked,
   output int                               empty_answers,
   output int                               rejected_discards,
   output int                               reclaimed_total
);
   timeunit 1ns;
   timeprecision 1ps;

   import tipdr_pkg::*;

   logic [SIZE_W-1:0] size_reg    [TYPE_COUNT];
   logic [IDX_W-1:0]  free_ring   [TYPE_COUNT][POOL_DEPTH];
   logic [IDX_W-1:0]  stale_ring  [TYPE_COUNT][POOL_DEPTH];
   int                free_head   [TYPE_COUNT];
   int                free_avail  [TYPE_COUNT];
   int                stale_avail [TYPE_COUNT];
   int                peak_held   [TYPE_COUNT];

   rsp_item_type      due_replies [$];

   // Register values above the depth behave as a full pool.
   function automatic int usable_size(input int pool);
      int s;
      s = int'(size_reg[pool]);
      return (s > POOL_DEPTH) ? POOL_DEPTH : s;
   endfunction

   function automatic void refill_pool(input int pool);
      int s;
      s = usable_size(pool);
      for (int i = 0; i < POOL_DEPTH; i++) begin
         free_ring[pool][i] = (i < s) ? IDX_W'(i) : '0;
      end
      free_head[pool]   = 0;
      free_avail[pool]  = s;
      stale_avail[pool] = 0;
      peak_held[pool]   = 0;
   endfunction

   // Applies one request to the pool copy and returns the answer it must give.
   function automatic rsp_item_type settle_request(input req_item_type item);
      rsp_item_type answer;
      int           qt;
      int           slot;
      int           in_use;
      int           moved;
      bit           known;
      answer = '0;
      moved  = 0;
      qt     = int'(item.pool_sel);
      known  = (qt < TYPE_COUNT);
      case (item.kind)
         OP_ALLOC: begin
            if (!known || free_avail[qt] == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               slot = (free_head[qt] + free_avail[qt] - 1) % POOL_DEPTH;
               answer.granted_index = free_ring[qt][slot];
               free_avail[qt]--;
               in_use = usable_size(qt) > free_avail[qt] ?
                        usable_size(qt) - free_avail[qt] : 0;
               if (in_use > peak_held[qt]) begin
                  peak_held[qt] = in_use;
               end
            end
         end
         OP_DISCARD: begin
            if (!known || int'(item.index) >= usable_size(qt) ||
                stale_avail[qt] >= POOL_DEPTH) begin
               answer.status = STATUS_RANGE;
            end else begin
               stale_ring[qt][stale_avail[qt]] = item.index;
               stale_avail[qt]++;
            end
         end
         OP_RESET_STALE: begin
            for (int k = 0; k < TYPE_COUNT; k++) begin
               for (int i = 0; i < stale_avail[k]; i++) begin
                  // A full free ring drops the index without counting it.
                  if (free_avail[k] < POOL_DEPTH) begin
                     free_head[k] = (free_head[k] + POOL_DEPTH - 1) % POOL_DEPTH;
                     free_ring[k][free_head[k]] = stale_ring[k][i];
                     free_avail[k]++;
                     moved++;
                  end
               end
               stale_avail[k] = 0;
            end
            answer.reset_count = RCNT_W'(moved);
         end
         default: begin
         end
      endcase
      answer.peak_in_use = known ? CNT_W'(peak_held[qt]) : '0;
      return answer;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("result field %s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      int           reg_idx;
      if (reset) begin
         for (int k = 0; k < TYPE_COUNT; k++) begin
            size_reg[k] = SIZE_RESET;
            refill_pool(k);
         end
         due_replies.delete();
         fail_count        = 0;
         replies_checked   = 0;
         empty_answers     = 0;
         rejected_discards = 0;
         reclaimed_total   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_idx = int'(csr_paddr) / 4;
            if (reg_idx < NUM_SIZE_REGS && reg_idx < TYPE_COUNT) begin
               size_reg[reg_idx] = csr_pwdata[SIZE_W-1:0];
               refill_pool(reg_idx);
            end
         end
         // A result can never belong to a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (due_replies.size() == 0) begin
               $error("result item arrived with nothing outstanding");
               fail_count++;
            end else begin
               want = due_replies.pop_front();
               compare_field("status", want.status, rsp_data.status);
               compare_field("granted_index", want.granted_index, rsp_data.granted_index);
               compare_field("reset_count", want.reset_count, rsp_data.reset_count);
               compare_field("peak_in_use", want.peak_in_use, rsp_data.peak_in_use);
               replies_checked++;
               if (want.status == STATUS_EMPTY) empty_answers++;
               if (want.status == STATUS_RANGE) rejected_discards++;
               reclaimed_total += int'(want.reset_count);
            end
         end
         if (req_valid && req_ready) begin
            due_replies = {due_replies, settle_request(req_data)};
         end
      end
      pending = due_replies.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the typed index pool
// Drives allocate, discard and reset-stale requests across many pool size
// settings, with random idling on both channels, while a checker module
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tipdr_pkg::*;

   // Register indexes of the five pool sizes.
   localparam int REG_OCCLUSION        = 0;
   localparam int REG_BINARY_OCCLUSION = 1;
   localparam int REG_TIMESTAMP        = 2;
   localparam int REG_PIPELINE_STATS   = 3;
   localparam int REG_DURATION         = 4;

   // Query kinds; the last two lie beyond the implemented kinds.
   localparam logic [TYPE_W-1:0] QT_OCCLUSION        = 3'd0;
   localparam logic [TYPE_W-1:0] QT_BINARY_OCCLUSION = 3'd1;
   localparam logic [TYPE_W-1:0] QT_TIMESTAMP        = 3'd2;
   localparam logic [TYPE_W-1:0] QT_PIPELINE_STATS   = 3'd3;
   localparam logic [TYPE_W-1:0] QT_DURATION         = 3'd4;
   localparam logic [TYPE_W-1:0] QT_FIRST_UNKNOWN    = TYPE_W'(TYPE_COUNT);
   localparam logic [TYPE_W-1:0] QT_LAST_UNKNOWN     = '1;

   // The one opcode the block leaves unused.
   localparam logic [OP_W-1:0]   OP_UNUSED           = 2'd3;

   localparam int SIZE_REG_MAX   = (1 << SIZE_W) - 1;
   localparam int INDEX_MAX      = POOL_DEPTH - 1;
   localparam int HOLD_CYCLES    = 240;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 145;
   localparam int BURST_ITEMS    = 30;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_item_type           req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int pending;
   int replies_checked;
   int empty_answers;
   int rejected_discards;
   int reclaimed_total;

   // Stimulus bookkeeping: the effective size of each pool, so that most
   // discards name an index the pool can actually take back.
   int pool_size [TYPE_COUNT];
   int items_sent    = 0;
   int size_writes   = 0;
   // While quiet is set neither side idles, but for a requested hold. hold_request
   // asks the receiver for one long stretch with ready low; it is raised at a
   // rising edge and the receiver acts on it once, at the next falling edge.
   bit quiet         = 1'b0;
   bit hold_request  = 1'b0;

   typed_index_pool_with_deferred_reclaim u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   index_pool_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .fail_count        (fail_count),
      .pending           (pending),
      .replies_checked   (replies_checked),
      .empty_answers     (empty_answers),
      .rejected_discards (rejected_discards),
      .reclaimed_total   (reclaimed_total)
   );

   always #5 clock = ~clock;

   // Safety net: a correct run needs a small fraction of this time, even
   // with every item met by the longest stalls on both sides.
   initial begin
      #100_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Idle length between items: mostly none or short, now and then a
   // long gap so that pauses land on every stage of the block's work.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(12, 45);
   endfunction

   function automatic req_item_type item_of(input logic [OP_W-1:0] kind,
                                            input logic [TYPE_W-1:0] qt,
                                            input int idx);
      req_item_type it;
      it.kind     = kind;
      it.pool_sel = qt;
      it.index    = IDX_W'(idx);
      return it;
   endfunction

   // Mostly well-formed traffic on the implemented kinds; a few requests name
   // a kind that does not exist or use the unused opcode.
   function automatic req_item_type random_item();
      req_item_type it;
      int           r;
      int           top_idx;
      r = $urandom_range(0, 99);
      if (r < 45)      it.kind = OP_ALLOC;
      else if (r < 85) it.kind = OP_DISCARD;
      else if (r < 94) it.kind = OP_RESET_STALE;
      else             it.kind = OP_UNUSED;
      if ($urandom_range(0, 99) < 92) begin
         it.pool_sel = TYPE_W'($urandom_range(0, TYPE_COUNT - 1));
      end else begin
         it.pool_sel = TYPE_W'($urandom_range(TYPE_COUNT, int'(QT_LAST_UNKNOWN)));
      end
      it.index = IDX_W'($urandom_range(0, INDEX_MAX));
      // Most discards stay inside the pool or just one past it, so both accepted
      // returns and the out-of-range rejection turn up often.
      if (it.kind == OP_DISCARD && it.pool_sel < QT_FIRST_UNKNOWN &&
          $urandom_range(0, 9) < 7) begin
         top_idx  = pool_size[it.pool_sel];
         it.index = IDX_W'($urandom_range(0, top_idx > INDEX_MAX ? INDEX_MAX : top_idx));
      end
      return it;
   endfunction

   // Small pools dominate, so that pools run dry and ranges are hit often;
   // the extremes and the odd large value still come up in most phases.
   function automatic int random_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 0;
      if (r < 14) return POOL_DEPTH;
      if (r < 20) return SIZE_REG_MAX;
      if (r < 25) return 1;
      if (r < 85) return $urandom_range(2, 12);
      return $urandom_range(13, SIZE_REG_MAX - 1);
   endfunction

   // Offers one item, holds it until it is taken, then idles at random unless quiet.
   task automatic send(input req_item_type item);
      int gap;
      @(negedge clock);
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      gap = quiet ? 0 : idle_length();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // Stops offering and waits until every result item has come back. Every
   // request answers exactly once, so the block is idle by then.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Setup cycle then access cycle; the write lands with pready high.
   task automatic write_size(input int reg_idx, input int value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'(4 * reg_idx);
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      pool_size[reg_idx] = (value > POOL_DEPTH) ? POOL_DEPTH : value;
      size_writes++;
   endtask

   // Receiver: random ready with short and long stalls, steady ready while
   // quiet, and one long hold-off on request, counted here in cycles.
   initial begin : receiver
      int stall;
      int r;
      bit hold_taken;
      stall      = 0;
      hold_taken = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready  = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (quiet) begin
            rsp_ready = 1'b1;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready = 1'b1;
            end else if (r < 94) begin
               rsp_ready = 1'b0;
               stall     = $urandom_range(0, 2);
            end else begin
               rsp_ready = 1'b0;
               stall     = $urandom_range(15, 50);
            end
         end
      end
   end

   initial begin : stimulus
      int settle;
      for (int k = 0; k < TYPE_COUNT; k++) pool_size[k] = POOL_DEPTH;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed, default sizes: unknown kinds on both operations, the
      // unused opcode, both index extremes, and a reclaim where the free
      // ring fills up so one returned index is dropped.
      send(item_of(OP_ALLOC, QT_OCCLUSION, 0));
      send(item_of(OP_ALLOC, QT_DURATION, INDEX_MAX));
      send(item_of(OP_ALLOC, QT_LAST_UNKNOWN, 0));
      send(item_of(OP_ALLOC, QT_FIRST_UNKNOWN, INDEX_MAX));
      send(item_of(OP_DISCARD, QT_OCCLUSION, INDEX_MAX));
      send(item_of(OP_DISCARD, QT_OCCLUSION, 0));
      send(item_of(OP_DISCARD, QT_LAST_UNKNOWN, 5));
      send(item_of(OP_UNUSED, QT_PIPELINE_STATS, INDEX_MAX));
      send(item_of(OP_UNUSED, QT_LAST_UNKNOWN, 0));
      send(item_of(OP_RESET_STALE, QT_OCCLUSION, 0));
      send(item_of(OP_ALLOC, QT_OCCLUSION, 0));
      send(item_of(OP_RESET_STALE, QT_LAST_UNKNOWN, INDEX_MAX));
      drain();

      // Directed, size extremes: a disabled pool, a single-entry pool, a
      // register value past the depth, the full depth and an odd size.
      write_size(REG_OCCLUSION, 0);
      write_size(REG_BINARY_OCCLUSION, 1);
      write_size(REG_TIMESTAMP, SIZE_REG_MAX);
      write_size(REG_PIPELINE_STATS, POOL_DEPTH);
      write_size(REG_DURATION, 33);
      send(item_of(OP_ALLOC, QT_OCCLUSION, 0));
      send(item_of(OP_DISCARD, QT_OCCLUSION, 0));
      send(item_of(OP_ALLOC, QT_BINARY_OCCLUSION, 0));
      send(item_of(OP_ALLOC, QT_BINARY_OCCLUSION, 0));
      send(item_of(OP_DISCARD, QT_BINARY_OCCLUSION, 1));
      send(item_of(OP_DISCARD, QT_BINARY_OCCLUSION, 0));
      send(item_of(OP_ALLOC, QT_TIMESTAMP, 0));
      send(item_of(OP_DISCARD, QT_DURATION, 33));
      send(item_of(OP_DISCARD, QT_DURATION, 32));
      send(item_of(OP_RESET_STALE, QT_DURATION, 0));
      send(item_of(OP_ALLOC, QT_BINARY_OCCLUSION, 0));
      drain();

      // Fill one stale list past its depth, so the last discards bounce,
      // then reclaim into a ring that fills at the depth and drops the rest.
      write_size(REG_TIMESTAMP, 8);
      repeat (3) send(item_of(OP_ALLOC, QT_TIMESTAMP, 0));
      repeat (POOL_DEPTH + 2) begin
         send(item_of(OP_DISCARD, QT_TIMESTAMP, $urandom_range(0, 7)));
      end
      send(item_of(OP_RESET_STALE, TYPE_W'($urandom_range(0, 7)),
                   $urandom_range(0, INDEX_MAX)));
      repeat (4) send(item_of(OP_ALLOC, QT_TIMESTAMP, 0));
      drain();

      // Random phases, each under a fresh set of pool sizes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         for (int k = 0; k < TYPE_COUNT; k++) write_size(k, random_size());
         @(posedge clock);
         quiet = (ph == 0 || ph == 7);
         settle = 0;
         if (ph == 3) begin
            // The receiver holds off while items keep coming back to back,
            // so the block fills up and has to refuse further requests.
            hold_request = 1'b1;
            quiet        = 1'b1;
            repeat (BURST_ITEMS) send(random_item());
            quiet  = 1'b0;
            settle = BURST_ITEMS;
         end
         for (int n = settle; n < PHASE_ITEMS; n++) begin
            // Halfway through one phase the sender waits until every
            // result is back before carrying on.
            if (ph == 6 && n == PHASE_ITEMS / 2) drain();
            send(random_item());
         end
         drain();
         quiet = 1'b0;
      end

      // Results are all in by now unless something went astray; a long
      // reclaim walk is well within the limit below.
      for (int n = 0; n < 20000 && pending != 0; n++) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pending != 0) begin
         $error("%0d expected result items never arrived", pending);
      end

      $display("Run covered %0d items and %0d checked results over %0d size writes.",
               items_sent, replies_checked, size_writes);
      $display("Seen: %0d empty pools, %0d rejected discards, %0d indices reclaimed.",
               empty_answers, rejected_discards, reclaimed_total);
      if (fail_count == 0 && pending == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/tipdr_pkg.sv
src/tipdr_ram.sv
src/tipdr_csr.sv
src/typed_index_pool_with_deferred_reclaim.sv
tb/sv/index_pool_checker.sv
tb/sv/tb.sv
